@@ rtl/core/anwi_pkg.sv @@
package anwi_pkg;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_MODE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESULT_WORDS = 1'd1;

   localparam logic [1:0] RADIX_MODE_RESET   = 2'd0;
   localparam logic [2:0] RESULT_WORDS_RESET = 3'd1;

   // Field widths.
   localparam int CHAR_W     = 8;
   localparam int VALUE_W    = 128;
   localparam int HALF_W     = 64;
   localparam int COUNT_W    = 8;
   localparam int STATUS_W   = 3;
   localparam int RSP_DATA_W = 144;

   // ASCII codes used by the classifier.
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOW_F = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LOW_X = 8'h78;
   localparam logic [3:0]        DIGIT_TEN = 4'hA;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      PH_EXPECT_ZERO = 2'd0,
      PH_EXPECT_X    = 2'd1,
      PH_NO_DIGIT    = 2'd2,
      PH_DIGITS      = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_NO_DIGITS      = 3'd1,
      ST_MISSING_PREFIX = 3'd2,
      ST_OVERFLOW       = 3'd3,
      ST_EXCEEDS_WORDS  = 3'd4
   } status_type;

   // One classified character as it travels from the front end to the back end.
   typedef struct packed {
      logic       first;
      logic       hex;
      logic       need_prefix;
      logic       is_zero;
      logic       is_x;
      logic       is_digit;
      logic [3:0] digit;
   } item_type;

   typedef struct packed {
      logic [HALF_W-1:0]   value_low;
      logic [HALF_W-1:0]   value_high;
      logic [COUNT_W-1:0]  consumed;
      status_type          status;
   } result_type;

endpackage

@@ rtl/core/anwi_front.sv @@
module anwi_front (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [anwi_pkg::CHAR_W-1:0] ch,
   input  logic                      first,
   input  logic [1:0]                radix_mode,
   input  logic                      queue_full,
   output logic                      push,
   output anwi_pkg::item_type        item
);
   import anwi_pkg::*;

   logic       hex;
   logic       is_dec;
   logic       is_low;
   logic       is_up;
   logic [3:0] digit;

   assign hex    = (radix_mode != 2'd0);
   assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_low = hex && (ch >= CH_LOW_A) && (ch <= CH_LOW_F);
   assign is_up  = hex && (ch >= CH_UP_A) && (ch <= CH_UP_F);

   always_comb begin
      if (is_dec) begin
         digit = 4'(ch - CH_ZERO);
      end else if (is_low) begin
         digit = 4'(ch - CH_LOW_A) + DIGIT_TEN;
      end else if (is_up) begin
         digit = 4'(ch - CH_UP_A) + DIGIT_TEN;
      end else begin
         digit = 4'd0;
      end
   end

   always_comb begin
      item.first       = first;
      item.hex         = hex;
      item.need_prefix = radix_mode[1];
      item.is_zero     = (ch == CH_ZERO);
      item.is_x        = (ch == CH_LOW_X);
      item.is_digit    = is_dec || is_low || is_up;
      item.digit       = digit;
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

@@ rtl/core/anwi_queue.sv @@
module anwi_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  anwi_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output anwi_pkg::item_type  head
);
   import anwi_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [IDX_W-1:0]   wr_ff, wr_in;
   logic [IDX_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/anwi_back.sv @@
module anwi_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  anwi_pkg::item_type  item,
   output logic                item_pop,
   input  logic [2:0]          result_words,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output anwi_pkg::result_type result
);
   import anwi_pkg::*;

   logic [VALUE_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   phase_type           phase_ff, phase_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          result_ff, result_in;

   logic                take;
   logic                active;
   logic [VALUE_W-1:0]  acc0;
   logic [COUNT_W-1:0]  cnt0;
   phase_type           phase0;
   logic [VALUE_W+3:0]  dec_sum;
   logic [VALUE_W-1:0]  mul_val;
   logic                mul_ovf;
   logic                advance;
   logic                fin;
   status_type          fin_status;
   phase_type           phase_next;
   logic [VALUE_W-1:0]  mask;
   logic [VALUE_W-1:0]  masked;

   assign item_pop = item_valid && (!rsp_valid_ff || rsp_ready);
   assign take     = item_pop;

   // Token start resets the working state before the character is applied.
   assign active = item.first || !done_ff;
   assign acc0   = item.first ? '0 : acc_ff;
   assign cnt0   = item.first ? '0 : cnt_ff;
   always_comb begin
      if (item.first) begin
         phase0 = item.need_prefix ? PH_EXPECT_ZERO : PH_NO_DIGIT;
      end else begin
         phase0 = phase_ff;
      end
   end

   // Times ten is (x << 3) + (x << 1); times sixteen is a plain shift.
   assign dec_sum = {1'b0, acc0, 3'b000} + {3'b000, acc0, 1'b0} + {128'd0, item.digit};
   assign mul_val = item.hex ? {acc0[VALUE_W-5:0], item.digit} : dec_sum[VALUE_W-1:0];
   assign mul_ovf = item.hex ? (|acc0[VALUE_W-1:VALUE_W-4]) : (|dec_sum[VALUE_W+3:VALUE_W]);

   // Event decode for the current character.
   always_comb begin
      advance    = 1'b0;
      fin        = 1'b0;
      fin_status = ST_OK;
      case (phase0)
         PH_EXPECT_ZERO: begin
            if (item.is_zero) begin
               advance = 1'b1;
            end else begin
               fin        = 1'b1;
               fin_status = ST_MISSING_PREFIX;
            end
         end
         PH_EXPECT_X: begin
            if (item.is_x) begin
               advance = 1'b1;
            end else begin
               fin        = 1'b1;
               fin_status = ST_MISSING_PREFIX;
            end
         end
         default: begin
            if (item.is_digit && (item.hex || item.digit < DIGIT_TEN)) begin
               if (mul_ovf) begin
                  fin        = 1'b1;
                  fin_status = ST_OVERFLOW;
               end else begin
                  advance = 1'b1;
               end
            end else begin
               fin        = 1'b1;
               fin_status = (phase0 == PH_NO_DIGIT) ? ST_NO_DIGITS : ST_OK;
            end
         end
      endcase
      if (!active) begin
         advance = 1'b0;
         fin     = 1'b0;
      end
   end

   // Next phase on an accepted prefix character or digit.
   always_comb begin
      case (phase0)
         PH_EXPECT_ZERO: phase_next = PH_EXPECT_X;
         PH_EXPECT_X:    phase_next = PH_NO_DIGIT;
         default:        phase_next = PH_DIGITS;
      endcase
   end

   always_comb begin
      case (result_words)
         3'd0:    mask = '0;
         3'd1:    mask = {96'd0, {32{1'b1}}};
         3'd2:    mask = {64'd0, {64{1'b1}}};
         3'd3:    mask = {32'd0, {96{1'b1}}};
         default: mask = '1;
      endcase
   end
   assign masked = acc0 & mask;

   // Result formatting.
   always_comb begin
      result_in = '0;
      if (fin_status == ST_OK) begin
         result_in.value_low  = masked[HALF_W-1:0];
         result_in.value_high = masked[VALUE_W-1:HALF_W];
         result_in.consumed   = cnt0;
         result_in.status     = (masked != acc0) ? ST_EXCEEDS_WORDS : ST_OK;
      end else begin
         result_in.status = fin_status;
      end
   end

   // Working state update.
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      done_in  = done_ff;
      if (take && active) begin
         acc_in   = acc0;
         cnt_in   = cnt0;
         phase_in = phase0;
         done_in  = 1'b0;
         if (advance) begin
            if (phase0 == PH_NO_DIGIT || phase0 == PH_DIGITS) begin
               acc_in = mul_val;
            end
            cnt_in   = (cnt0 == COUNT_MAX) ? cnt0 : cnt0 + 1'b1;
            phase_in = phase_next;
         end
         if (fin) begin
            done_in = 1'b1;
         end
      end
      rsp_valid_in = (take && fin) ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         phase_ff     <= PH_EXPECT_ZERO;
         done_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && fin) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

@@ rtl/core/ascii_number_to_wide_integer.sv @@
// ASCII number parser: one character per request on the req_ channel, one result per
// finished token on the rsp_ channel. A character flagged in req_tuser starts a token;
// the token ends at the first character that is not a digit of the selected radix (or
// at a broken "0x" prefix, or at a digit that overflows 128 bits). That ending
// character belongs to no token. The result carries the value, the character count
// and a status code. Radix and allowed word count come from the csr_ write port,
// which the user must write only while the block is idle; the block does not enforce
// it. A front end classifies each character and writes it into a small queue; a back
// end pops one entry per cycle unless a held result stalls it, and runs the 128-bit
// multiply-add. An accepted character is registered in a queue slot and its result,
// if any, in the rsp_ result register. The sustained rate is one character per cycle
// while the receiver does not stall, set by the shift-add accumulator loop in the
// back end. When the receiver stalls, the held result blocks the back end, the queue
// fills after at most QUEUE_DEPTH more requests and req_tready then drops.
// Reset empties the queue, clears rsp_tvalid, sets the radix to decimal and the
// word count to one, and leaves the parser idle until a character flagged as first.
module ascii_number_to_wide_integer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] ch
   input  logic                                req_tuser,  // [0] first
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] value_low, [127:64] value_high, [135:128] consumed, [138:136] status,
   // [143:139] zero
   output logic [anwi_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [anwi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [anwi_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import anwi_pkg::*;

   logic [1:0]  radix_mode_ff, radix_mode_in;
   logic [2:0]  result_words_ff, result_words_in;

   logic        queue_full;
   logic        queue_empty;
   logic        push;
   logic        pop;
   item_type    push_item;
   item_type    head_item;
   result_type  result;

   // Configuration registers. Writes to an index outside the list are dropped.
   always_comb begin
      radix_mode_in   = radix_mode_ff;
      result_words_in = result_words_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_RADIX_MODE:   radix_mode_in   = csr_wdata[1:0];
            CSR_RESULT_WORDS: result_words_in = csr_wdata;
            default: begin
               radix_mode_in   = radix_mode_ff;
               result_words_in = result_words_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_mode_ff   <= RADIX_MODE_RESET;
         result_words_ff <= RESULT_WORDS_RESET;
      end else begin
         radix_mode_ff   <= radix_mode_in;
         result_words_ff <= result_words_in;
      end
   end

   // Front end: handshake and character classification.
   anwi_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .ch         (req_tdata),
      .first      (req_tuser),
      .radix_mode (radix_mode_ff),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // Queue between the front and back ends.
   anwi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head_item)
   );

   // Back end: token state, accumulator and result register.
   anwi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (!queue_empty),
      .item         (head_item),
      .item_pop     (pop),
      .result_words (result_words_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .result       (result)
   );

   assign rsp_tdata = {5'd0, result.status, result.consumed, result.value_high,
                       result.value_low};

endmodule
